// ===== src/sdre_pkg.sv =====
// ============================================================================
// sdre_pkg
// Types, codes and helpers shared by the signed radix digit emitter.
// ============================================================================
package sdre_pkg;

    localparam int VALUE_W    = 32;
    localparam int SYM_W      = 8;
    localparam int NUM_SYMS   = 16;
    localparam int SYM_IDX_W  = 4;
    localparam int RADIX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_DONE,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    // Control from the sequencer to the digit cells.
    typedef struct packed {
        logic clear;
        logic shift;
        logic bit_in;
    } t_cell_ctl;

    function automatic logic [SYM_W-1:0] sym_at(
        input logic [NUM_SYMS*SYM_W-1:0] syms,
        input logic [SYM_IDX_W-1:0]      idx
    );
        return syms[idx*SYM_W +: SYM_W];
    endfunction

endpackage

// ===== src/sdre_digit_cells.sv =====
// ============================================================================
// sdre_digit_cells
// Row of radix-r cells absorbing a binary number one bit per cycle on shift.
// ============================================================================
module sdre_digit_cells
    import sdre_pkg::*;
#(
    parameter int NDIG  = 32,
    parameter int DIG_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic [RADIX_W-1:0]         i_radix,
    input  logic [$clog2(NDIG)-1:0]    i_rd_idx,
    output logic [DIG_W-1:0]           o_digit,
    output logic [$clog2(NDIG+1)-1:0]  o_count
);

    localparam int KW = $clog2(NDIG + 1);

    logic [DIG_W-1:0] r_dig [NDIG];
    logic [DIG_W-1:0] n_dig [NDIG];
    logic [KW-1:0]    r_count;
    logic [KW-1:0]    n_count;

    logic [NDIG-1:0]  gen;
    logic [NDIG-1:0]  prop;
    logic [NDIG-1:0]  alt;
    logic [NDIG:0]    sum;
    logic [NDIG:0]    carry;

    // Each cell doubles its digit and adds the carry from below. A cell
    // generates a carry when twice its digit reaches the radix, and passes
    // an incoming carry on when twice its digit is exactly one below it.
    // The chain is resolved with one adder, whose internal carries are
    // exactly the cell carries.
    always_comb begin
        logic [RADIX_W-1:0] two;
        logic [RADIX_W-1:0] t;
        for (int i = 0; i < NDIG; i++) begin
            two     = RADIX_W'({r_dig[i], 1'b0});
            gen[i]  = (two >= i_radix);
            prop[i] = ((two | RADIX_W'(1)) == i_radix);
        end
        alt   = gen | prop;
        sum   = {1'b0, alt} + {1'b0, gen} + (NDIG+1)'(i_ctl.bit_in);
        carry = sum ^ {1'b0, alt} ^ {1'b0, gen};
        for (int i = 0; i < NDIG; i++) begin
            two = RADIX_W'({r_dig[i], 1'b0});
            t   = two | RADIX_W'(carry[i]);
            if (carry[i+1]) begin
                t = t - i_radix;
            end
            n_dig[i] = DIG_W'(t);
        end
        n_count = r_count + KW'(carry[r_count]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            for (int i = 0; i < NDIG; i++) begin
                r_dig[i] <= '0;
            end
        end else if (i_ctl.shift) begin
            for (int i = 0; i < NDIG; i++) begin
                r_dig[i] <= n_dig[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.shift) begin
            r_count <= n_count;
        end
    end

    assign o_digit = r_dig[i_rd_idx];
    assign o_count = r_count;

endmodule

// ===== src/signed_radix_digit_emitter_unit.sv =====
// ============================================================================
// signed_radix_digit_emitter_unit
// Writes a signed integer as a run of character bytes in a configured radix.
// ============================================================================
// Flow: an accepted item first goes through the bit-serial conversion pass,
// then leaves one character per cycle, up to VALUE_BITS + 1 of them. No new
// item is accepted while busy, that is until its last character is issued.
// Reset (synchronous, active low) clears the configuration and goes idle;
// the receiver cannot stall, so every character is shown for one cycle.
module signed_radix_digit_emitter_unit
    import sdre_pkg::*;
#(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Item input.
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VALUE_W-1:0] i_value,
    // Character output.
    output logic                    o_strobe,
    output logic [SYM_W-1:0]        o_symbol,
    output logic                    o_last,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // Magnitudes up to 2^(VALUE_BITS-1) need at most VALUE_BITS digits.
    localparam int NDIG  = VALUE_BITS;
    localparam int DIG_W = $clog2(MAX_RADIX);
    localparam int PHASE = (VALUE_BITS > MAX_RADIX) ? VALUE_BITS : MAX_RADIX;
    localparam int PW    = $clog2(PHASE);
    localparam int IW    = $clog2(NDIG);
    localparam int KW    = $clog2(NDIG + 1);

    // Configuration registers.
    logic [RADIX_W-1:0]        r_radix;
    logic [NUM_SYMS*SYM_W-1:0] r_syms;

    // Sequencer state.
    t_state            r_state,  n_state;
    logic [PW-1:0]     r_phase,  n_phase;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic              r_neg,    n_neg;
    logic              r_ok,     n_ok;
    logic [IW-1:0]     r_emit,   n_emit;

    // Output registers.
    logic              r_strobe, n_strobe;
    logic [SYM_W-1:0]  r_symbol, n_symbol;
    logic              r_last,   n_last;

    t_cell_ctl         cell_ctl;
    logic [DIG_W-1:0]  cell_digit;
    logic [KW-1:0]     cell_count;

    // The configuration port never pushes back; the user must write only while
    // the block is idle, as the block itself does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= '0;
            r_syms  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIX:   r_radix <= i_cfg_data[RADIX_W-1:0];
                CFG_SYM_LOW: r_syms[CFG_DATA_W-1:0] <= i_cfg_data;
                CFG_SYM_HI:  r_syms[2*CFG_DATA_W-1:CFG_DATA_W] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The digit cells take the magnitude most significant bit first. Every
    // bit doubles the number held in the cells and adds the new bit, so after
    // VALUE_BITS shifts the cells hold the magnitude in the configured radix
    // and the count says how many of them are significant.
    sdre_digit_cells #(
        .NDIG  (NDIG),
        .DIG_W (DIG_W)
    ) u_cells (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (cell_ctl),
        .i_radix  (r_radix),
        .i_rd_idx (r_emit),
        .o_digit  (cell_digit),
        .o_count  (cell_count)
    );

    // While the bits go in, the alphabet is checked one symbol per cycle:
    // the symbol at the current position is compared against the sign
    // characters and against every symbol below it. The conversion pass is
    // long enough to cover all symbol positions as well as all value bits.
    always_comb begin
        logic [VALUE_BITS-1:0] v;
        logic [SYM_IDX_W-1:0]  chk_idx;
        logic [SYM_W-1:0]      chk_sym;
        logic                  chk_bad;

        n_state  = r_state;
        n_phase  = r_phase;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_ok     = r_ok;
        n_emit   = r_emit;
        n_strobe = 1'b0;
        n_symbol = r_symbol;
        n_last   = 1'b0;
        cell_ctl = '0;

        v       = VALUE_BITS'(i_value);
        chk_idx = SYM_IDX_W'(r_phase);
        chk_sym = sym_at(r_syms, chk_idx);
        chk_bad = (chk_sym == CH_PLUS) || (chk_sym == CH_MINUS);
        for (int j = 0; j < MAX_RADIX; j++) begin
            if ((j < int'(chk_idx)) &&
                (sym_at(r_syms, SYM_IDX_W'(j)) == chk_sym)) begin
                chk_bad = 1'b1;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    cell_ctl.clear = 1'b1;
                    n_neg   = v[VALUE_BITS-1];
                    n_mag   = v[VALUE_BITS-1] ? (~v + VALUE_BITS'(1)) : v;
                    n_ok    = (r_radix >= RADIX_W'(2)) &&
                              (int'(r_radix) <= MAX_RADIX);
                    n_phase = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (int'(r_phase) < VALUE_BITS) begin
                    cell_ctl.shift  = 1'b1;
                    cell_ctl.bit_in = r_mag[VALUE_BITS-1];
                    n_mag = r_mag << 1;
                end
                if ((int'(r_phase) < MAX_RADIX) &&
                    (int'(r_phase) < int'(r_radix)) && chk_bad) begin
                    n_ok = 1'b0;
                end
                if (int'(r_phase) == PHASE - 1) begin
                    n_state = ST_DONE;
                end else begin
                    n_phase = r_phase + PW'(1);
                end
            end
            ST_DONE: begin
                // A zero value has no significant digit; it still shows
                // the lowest cell, which holds zero.
                n_emit = (cell_count == '0) ? '0 : IW'(cell_count - KW'(1));
                if (!r_ok) begin
                    n_state = ST_IDLE;
                end else if (r_neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_DIGITS;
                end
            end
            ST_SIGN: begin
                n_strobe = 1'b1;
                n_symbol = CH_MINUS;
                n_state  = ST_DIGITS;
            end
            ST_DIGITS: begin
                n_strobe = 1'b1;
                n_symbol = sym_at(r_syms, SYM_IDX_W'(cell_digit));
                if (r_emit == '0) begin
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_emit = r_emit - IW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Working and output data registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_ok     <= n_ok;
        r_emit   <= n_emit;
        r_symbol <= n_symbol;
        r_last   <= n_last;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

endmodule
